### hdl/script_lexer_scanner_top_defines.svh
// Assertion macros shared by the scanner modules.
// No dependencies; included by files that carry assertions.
`ifndef SCRIPT_LEXER_SCANNER_TOP_DEFINES_SVH
`define SCRIPT_LEXER_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// Next-cycle implication, disabled during reset.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

### hdl/sls_pkg.sv
// Shared types, token codes and keyword table for the lexical scanner.
// No dependencies.
`timescale 1ns / 1ps

package sls_pkg;

   // Token kinds
   localparam logic [5:0] K_LEFT_PAREN  = 6'd0;
   localparam logic [5:0] K_RIGHT_PAREN = 6'd1;
   localparam logic [5:0] K_LEFT_BRACE  = 6'd2;
   localparam logic [5:0] K_RIGHT_BRACE = 6'd3;
   localparam logic [5:0] K_COMMA       = 6'd4;
   localparam logic [5:0] K_DOT         = 6'd5;
   localparam logic [5:0] K_MINUS       = 6'd6;
   localparam logic [5:0] K_PLUS        = 6'd7;
   localparam logic [5:0] K_SEMICOLON = 6'd8;
   localparam logic [5:0] K_SLASH     = 6'd9;
   localparam logic [5:0] K_STAR      = 6'd10;
   localparam logic [5:0] K_BANG      = 6'd11;
   localparam logic [5:0] K_EQUAL     = 6'd13;
   localparam logic [5:0] K_GREATER   = 6'd15;
   localparam logic [5:0] K_LESS      = 6'd17;
   localparam logic [5:0] K_IDENT     = 6'd19;
   localparam logic [5:0] K_STRING    = 6'd20;
   localparam logic [5:0] K_NUMBER    = 6'd21;
   localparam logic [5:0] K_KEYWORD0  = 6'd22;
   localparam logic [5:0] K_END       = 6'd38;
   localparam logic [5:0] K_NONE      = 6'd0;

   // Error codes
   localparam logic [1:0] E_NONE   = 2'd0;
   localparam logic [1:0] E_CHAR   = 2'd1;
   localparam logic [1:0] E_STRING = 2'd2;
   localparam logic [1:0] E_NUMBER = 2'd3;

   // Character codes
   localparam logic [7:0] C_TAB    = 8'h09;
   localparam logic [7:0] C_LF     = 8'h0A;
   localparam logic [7:0] C_CR     = 8'h0D;
   localparam logic [7:0] C_SPACE  = 8'h20;
   localparam logic [7:0] C_BANG   = 8'h21;
   localparam logic [7:0] C_QUOTE  = 8'h22;
   localparam logic [7:0] C_STAR   = 8'h2A;
   localparam logic [7:0] C_SLASH  = 8'h2F;
   localparam logic [7:0] C_LESS   = 8'h3C;
   localparam logic [7:0] C_EQUAL  = 8'h3D;
   localparam logic [7:0] C_GREATER = 8'h3E;

   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   // Scanner modes, one-hot
   typedef enum logic [9:0] {
      M_IDLE    = 10'b0000000001,
      M_BANG    = 10'b0000000010,
      M_EQUAL   = 10'b0000000100,
      M_LESS    = 10'b0000001000,
      M_GREATER = 10'b0000010000,
      M_SLASH   = 10'b0000100000,
      M_COMMENT = 10'b0001000000,
      M_STRING  = 10'b0010000000,
      M_NUMBER  = 10'b0100000000,
      M_IDENT   = 10'b1000000000
   } mode_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [1:0]  error_code;
      logic [15:0] start_offset;
      logic [15:0] lexeme_length;
      logic [15:0] line_number;
      logic        last_of_run;
   } result_type;

   // Up to two results from one item; valid1 implies valid0
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type item0;
      result_type item1;
   } push_type;

   // Keywords packed big-endian into the low bytes, with lengths
   localparam logic [63:0] KW_TEXT [16] = '{
      64'h616E64,       64'h636C617373,   64'h656C7365,     64'h66616C7365,
      64'h66756E63,     64'h666F72,       64'h6966,         64'h6E696C,
      64'h6F72,         64'h7072696E74,   64'h72657475726E, 64'h7375706572,
      64'h74686973,     64'h74727565,     64'h766172,       64'h7768696C65
   };
   localparam logic [15:0] KW_LEN [16] = '{
      16'd3, 16'd5, 16'd4, 16'd5, 16'd4, 16'd3, 16'd2, 16'd3,
      16'd2, 16'd5, 16'd6, 16'd5, 16'd4, 16'd4, 16'd3, 16'd5
   };

   function automatic logic [5:0] word_kind(input logic [63:0] prefix,
                                            input logic [15:0] len);
      logic [5:0] kind;
      kind = K_IDENT;
      for (int i = 0; i < 16; i++) begin
         if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
            kind = K_KEYWORD0 + 6'(i);
         end
      end
      return kind;
   endfunction

   // Single-byte tokens ( ) { } , . - + ; map to kinds 0..8
   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         8'h28:   r = {1'b1, K_LEFT_PAREN};
         8'h29:   r = {1'b1, K_RIGHT_PAREN};
         8'h7B:   r = {1'b1, K_LEFT_BRACE};
         8'h7D:   r = {1'b1, K_RIGHT_BRACE};
         8'h2C:   r = {1'b1, K_COMMA};
         8'h2E:   r = {1'b1, K_DOT};
         8'h2D:   r = {1'b1, K_MINUS};
         8'h2B:   r = {1'b1, K_PLUS};
         8'h3B:   r = {1'b1, K_SEMICOLON};
         default: r = {1'b0, K_NONE};
      endcase
      return r;
   endfunction

endpackage

### hdl/sls_scanner_core.sv
// Scanner state and per-byte token logic; produces up to two results per item.
// Depends on sls_pkg and script_lexer_scanner_top_defines.svh.
`timescale 1ns / 1ps
`include "script_lexer_scanner_top_defines.svh"

module sls_scanner_core #(
   parameter int MAX_SOURCE    = 65536,
   parameter int KEYWORD_CHARS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_code,
   input  logic              end_of_source,
   output sls_pkg::push_type push
);

   localparam int POS_W  = $clog2(MAX_SOURCE) + 1;
   localparam int WORD_W = 8 * KEYWORD_CHARS;

   sls_pkg::mode_type mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       start_ff, start_in;
   logic [15:0]       line_ff, line_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [15:0]       wlen_ff, wlen_in;
   logic              halted_ff, halted_in;

   sls_pkg::result_type a_item, b_item;
   logic                a_v, b_v;
   logic                consumed, bump;
   logic [15:0]         pos16, len_cur;
   logic [5:0]          base, wkind;
   logic [6:0]          single;
   logic                is_digit, is_alpha, is_space;

   assign pos16    = 16'(pos_ff);
   assign len_cur  = pos16 - start_ff;
   assign wkind    = sls_pkg::word_kind(64'(word_ff), wlen_ff);
   assign single   = sls_pkg::single_kind(char_code);
   assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
   assign is_alpha = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                     ((char_code >= 8'h41) && (char_code <= 8'h5A));
   assign is_space = (char_code == sls_pkg::C_SPACE) ||
                     ((char_code >= sls_pkg::C_TAB) && (char_code <= sls_pkg::C_CR));

   // Base kind of a pending one-or-two-byte operator
   always_comb begin
      unique case (mode_ff)
         sls_pkg::M_BANG:  base = sls_pkg::K_BANG;
         sls_pkg::M_EQUAL: base = sls_pkg::K_EQUAL;
         sls_pkg::M_LESS:  base = sls_pkg::K_LESS;
         default:          base = sls_pkg::K_GREATER;
      endcase
   end

   // Next state and results: slot a from the pending token, slot b from a new one
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      line_in   = line_ff;
      word_in   = word_ff;
      wlen_in   = wlen_ff;
      halted_in = halted_ff;
      a_v       = 1'b0;
      b_v       = 1'b0;
      a_item    = '{sls_pkg::K_NONE, sls_pkg::E_NONE, start_ff, 16'd1, line_ff, 1'b0};
      b_item    = '{sls_pkg::K_NONE, sls_pkg::E_NONE, pos16, 16'd1, line_ff, 1'b0};
      consumed  = 1'b0;
      bump      = 1'b0;

      if (accept && !halted_ff) begin
         if (end_of_source) begin
            // flush the pending token, then the end token
            mode_in = sls_pkg::M_IDLE;
            unique case (mode_ff) inside
               sls_pkg::M_BANG, sls_pkg::M_EQUAL, sls_pkg::M_LESS,
               sls_pkg::M_GREATER: begin
                  a_v = 1'b1;
                  a_item.token_kind = base;
               end
               sls_pkg::M_SLASH: begin
                  a_v = 1'b1;
                  a_item.token_kind = sls_pkg::K_SLASH;
               end
               sls_pkg::M_STRING: begin
                  a_v = 1'b1;
                  a_item.error_code    = sls_pkg::E_STRING;
                  a_item.lexeme_length = len_cur;
               end
               sls_pkg::M_NUMBER: begin
                  a_v = 1'b1;
                  a_item.token_kind    = sls_pkg::K_NUMBER;
                  a_item.lexeme_length = len_cur;
               end
               sls_pkg::M_IDENT: begin
                  a_v = 1'b1;
                  a_item.token_kind    = wkind;
                  a_item.lexeme_length = len_cur;
               end
               default: ;
            endcase
            b_v = 1'b1;
            b_item.token_kind    = sls_pkg::K_END;
            b_item.lexeme_length = 16'd0;
         end else if (pos_ff < POS_W'(MAX_SOURCE)) begin
            pos_in = pos_ff + 1'b1;
            // continue the pending token
            unique case (mode_ff) inside
               sls_pkg::M_BANG, sls_pkg::M_EQUAL, sls_pkg::M_LESS,
               sls_pkg::M_GREATER: begin
                  mode_in = sls_pkg::M_IDLE;
                  a_v     = 1'b1;
                  if (char_code == sls_pkg::C_EQUAL) begin
                     a_item.token_kind    = base + 6'd1;
                     a_item.lexeme_length = 16'd2;
                     consumed             = 1'b1;
                  end else begin
                     a_item.token_kind = base;
                  end
               end
               sls_pkg::M_SLASH: begin
                  if (char_code == sls_pkg::C_SLASH) begin
                     mode_in  = sls_pkg::M_COMMENT;
                     consumed = 1'b1;
                  end else begin
                     mode_in = sls_pkg::M_IDLE;
                     a_v     = 1'b1;
                     a_item.token_kind = sls_pkg::K_SLASH;
                  end
               end
               sls_pkg::M_COMMENT: begin
                  if (char_code == sls_pkg::C_LF) begin
                     mode_in = sls_pkg::M_IDLE;
                  end else begin
                     consumed = 1'b1;
                  end
               end
               sls_pkg::M_STRING: begin
                  consumed = 1'b1;
                  if (char_code == sls_pkg::C_QUOTE) begin
                     mode_in = sls_pkg::M_IDLE;
                     a_v     = 1'b1;
                     a_item.token_kind    = sls_pkg::K_STRING;
                     a_item.lexeme_length = len_cur + 16'd1;
                  end else if (char_code == sls_pkg::C_LF) begin
                     bump = 1'b1;
                  end
               end
               sls_pkg::M_NUMBER: begin
                  if (is_digit) begin
                     consumed = 1'b1;
                  end else begin
                     mode_in = sls_pkg::M_IDLE;
                     a_v     = 1'b1;
                     a_item.lexeme_length = len_cur;
                     if (is_space) begin
                        a_item.token_kind = sls_pkg::K_NUMBER;
                     end else begin
                        a_item.error_code = sls_pkg::E_NUMBER;
                        halted_in = 1'b1;
                        consumed  = 1'b1;
                     end
                  end
               end
               sls_pkg::M_IDENT: begin
                  if (is_alpha) begin
                     consumed = 1'b1;
                     if (wlen_ff < 16'(KEYWORD_CHARS)) begin
                        word_in = {word_ff[WORD_W-9:0], char_code};
                     end
                     if (wlen_ff != sls_pkg::LINE_MAX) begin
                        wlen_in = wlen_ff + 16'd1;
                     end
                  end else begin
                     mode_in = sls_pkg::M_IDLE;
                     a_v     = 1'b1;
                     a_item.token_kind    = wkind;
                     a_item.lexeme_length = len_cur;
                  end
               end
               default: ;
            endcase

            // start a new token with an unconsumed byte
            if (!consumed) begin
               start_in = pos16;
               if (single[6]) begin
                  b_v = 1'b1;
                  b_item.token_kind = single[5:0];
               end else begin
                  case (char_code) inside
                     sls_pkg::C_STAR: begin
                        b_v = 1'b1;
                        b_item.token_kind = sls_pkg::K_STAR;
                     end
                     sls_pkg::C_BANG:    mode_in = sls_pkg::M_BANG;
                     sls_pkg::C_EQUAL:   mode_in = sls_pkg::M_EQUAL;
                     sls_pkg::C_LESS:    mode_in = sls_pkg::M_LESS;
                     sls_pkg::C_GREATER: mode_in = sls_pkg::M_GREATER;
                     sls_pkg::C_SLASH:   mode_in = sls_pkg::M_SLASH;
                     sls_pkg::C_SPACE, sls_pkg::C_CR, sls_pkg::C_TAB: ;
                     sls_pkg::C_LF:      bump    = 1'b1;
                     sls_pkg::C_QUOTE:   mode_in = sls_pkg::M_STRING;
                     default: begin
                        if (is_digit) begin
                           mode_in = sls_pkg::M_NUMBER;
                        end else if (is_alpha) begin
                           mode_in = sls_pkg::M_IDENT;
                           word_in = WORD_W'(char_code);
                           wlen_in = 16'd1;
                        end else begin
                           b_v = 1'b1;
                           b_item.error_code = sls_pkg::E_CHAR;
                        end
                     end
                  endcase
               end
            end

            if (bump && line_ff != sls_pkg::LINE_MAX) begin
               line_in = line_ff + 16'd1;
            end
         end
      end
   end

   // Pack results in order and flag the last one
   always_comb begin
      push = '0;
      if (a_v) begin
         push.valid0 = 1'b1;
         push.valid1 = b_v;
         push.item0  = a_item;
         push.item1  = b_item;
      end else begin
         push.valid0 = b_v;
         push.item0  = b_item;
      end
      push.item0.last_of_run = !push.valid1;
      push.item1.last_of_run = 1'b1;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sls_pkg::M_IDLE;
         pos_ff    <= '0;
         start_ff  <= '0;
         line_ff   <= 16'd1;
         word_ff   <= '0;
         wlen_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         line_ff   <= line_in;
         word_ff   <= word_in;
         wlen_ff   <= wlen_in;
         halted_ff <= halted_in;
      end
   end

   `SLS_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `SLS_ASSERT_NEXT(a_end_idle, clock, reset, accept && end_of_source && !halted_ff,
                    mode_ff == sls_pkg::M_IDLE)

endmodule

### hdl/sls_result_fifo.sv
// Four-entry result queue taking up to two results per cycle, one out per cycle while out_stall is low.
// Depends on sls_pkg and script_lexer_scanner_top_defines.svh.
`timescale 1ns / 1ps
`include "script_lexer_scanner_top_defines.svh"

module sls_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  sls_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_stall,
   output sls_pkg::result_type out_item
);

   localparam int DEPTH = 4;

   sls_pkg::result_type mem [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] n_push;

   assign out_valid = (count_ff != 3'd0);
   assign out_item  = mem[rd_ff];
   assign pop       = out_valid && !out_stall;
   assign room      = (count_ff <= 3'(DEPTH - 2));
   assign n_push    = {1'b0, push.valid0} + {1'b0, push.valid1};

   // Pointer and fill count
   always_comb begin
      wr_in    = wr_ff + n_push;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, n_push} - {2'b00, pop};
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem[wr_ff] <= push.item0;
      end
      if (push.valid1) begin
         mem[wr_ff + 2'd1] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `SLS_ASSERT_NOW(a_no_overflow, clock, reset, 1'b1, count_ff <= 3'(DEPTH))
   `SLS_ASSERT_NOW(a_push_room, clock, reset, push.valid0, room)

endmodule

### hdl/script_lexer_scanner_top.sv
// Channel   Ports                                   Direction
// req       req_valid/req_stall, char, end flag      in
// rsp       rsp_valid/rsp_stall, token fields        out
//
// One byte per cycle while req_stall is low: all token logic sits between the scanner state
// registers and a four-entry result queue. An item yields zero to two results.
// req_stall rises when the queue has fewer than two free entries.
// Reset is synchronous and clears scanner state and the queue.
// Top level of the lexical scanner; depends on sls_pkg, sls_scanner_core, sls_result_fifo.
`timescale 1ns / 1ps

module script_lexer_scanner_top #(
   parameter int MAX_SOURCE    = 65536,
   parameter int KEYWORD_CHARS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_lexeme_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_of_run
);

   sls_pkg::push_type   push;
   sls_pkg::result_type head;
   logic                room;
   logic                accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   sls_scanner_core #(
      .MAX_SOURCE    (MAX_SOURCE),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_code     (req_char_code),
      .end_of_source (req_end_of_source),
      .push          (push)
   );

   sls_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (head)
   );

   assign rsp_token_kind    = head.token_kind;
   assign rsp_error_code    = head.error_code;
   assign rsp_start_offset  = head.start_offset;
   assign rsp_lexeme_length = head.lexeme_length;
   assign rsp_line_number   = head.line_number;
   assign rsp_last_of_run   = head.last_of_run;

endmodule

### bench/tb_script_lexer_scanner_top.sv
// Testbench for the lexical scanner: drives byte streams, predicts tokens
// with a behavioral scanner model and checks every result item in order.
// Depends on sls_pkg and script_lexer_scanner_top.
`timescale 1ns / 1ps

module tb_script_lexer_scanner_top;

   localparam int SRC_LIMIT = 65536;
   localparam int KW_CHARS  = 6;
   localparam int WATCHDOG  = 20000;

   // predictor modes
   typedef enum int {
      P_IDLE, P_BANG, P_EQUAL, P_LESS, P_GREATER, P_SLASH,
      P_COMMENT, P_STRING, P_NUMBER, P_IDENT
   } scan_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'd0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [1:0]  rsp_error_code;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_lexeme_length;
   logic [15:0] rsp_line_number;
   logic        rsp_last_of_run;

   script_lexer_scanner_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_code(req_char_code), .req_end_of_source(req_end_of_source),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind), .rsp_error_code(rsp_error_code),
      .rsp_start_offset(rsp_start_offset), .rsp_lexeme_length(rsp_lexeme_length),
      .rsp_line_number(rsp_line_number), .rsp_last_of_run(rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // predictor state
   scan_mode_type mode_q;
   int unsigned   pos_q, tok_start_q, line_q, word_len_q;
   logic [63:0]   prefix_q;
   bit            halted_q;

   sls_pkg::result_type token_queue[$];
   sls_pkg::result_type step_out[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;
   int          hold_off = 0;

   // keyword text, big-endian in low bytes
   string kw_words[16] = '{"and", "class", "else", "false", "func", "for", "if",
      "nil", "or", "print", "return", "super", "this", "true", "var", "while"};

   task automatic add_token(input logic [5:0] kind, input logic [1:0] err,
                            input int unsigned start, input int unsigned len);
      sls_pkg::result_type r;
      r.token_kind    = kind;
      r.error_code    = err;
      r.start_offset  = start[15:0];
      r.lexeme_length = len[15:0];
      r.line_number   = line_q[15:0];
      r.last_of_run   = 1'b0;
      if (step_out.size() < 2) step_out = {step_out, r};
   endtask

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit is_blank(input logic [7:0] c);
      return c == sls_pkg::C_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   task automatic bump_line();
      if (line_q < 65535) line_q++;
   endtask

   task automatic add_word();
      logic [5:0]  kind;
      logic [63:0] packed_kw;
      kind = sls_pkg::K_IDENT;
      for (int i = 15; i >= 0; i--) begin
         packed_kw = 0;
         for (int j = 0; j < kw_words[i].len() && j < KW_CHARS; j++)
            packed_kw = (packed_kw << 8) | kw_words[i][j];
         if (word_len_q == kw_words[i].len() && prefix_q == packed_kw)
            kind = sls_pkg::K_KEYWORD0 + 6'(i);
      end
      add_token(kind, sls_pkg::E_NONE, tok_start_q, pos_q - tok_start_q);
   endtask

   function automatic logic [5:0] op_kind(input scan_mode_type m);
      case (m)
         P_BANG:  return sls_pkg::K_BANG;
         P_EQUAL: return sls_pkg::K_EQUAL;
         P_LESS:  return sls_pkg::K_LESS;
         default: return sls_pkg::K_GREATER;
      endcase
   endfunction

   // returns 1 when the pending token consumed the byte
   task automatic continue_token(input logic [7:0] c, output bit used);
      used = 1'b0;
      case (mode_q) inside
         P_BANG, P_EQUAL, P_LESS, P_GREATER: begin
            if (c == sls_pkg::C_EQUAL) begin
               add_token(op_kind(mode_q) + 6'd1, sls_pkg::E_NONE, tok_start_q, 2);
               used = 1'b1;
            end else add_token(op_kind(mode_q), sls_pkg::E_NONE, tok_start_q, 1);
            mode_q = P_IDLE;
         end
         P_SLASH: begin
            if (c == sls_pkg::C_SLASH) begin
               mode_q = P_COMMENT;
               used = 1'b1;
            end else begin
               mode_q = P_IDLE;
               add_token(sls_pkg::K_SLASH, sls_pkg::E_NONE, tok_start_q, 1);
            end
         end
         P_COMMENT: begin
            if (c == sls_pkg::C_LF) mode_q = P_IDLE;
            else used = 1'b1;
         end
         P_STRING: begin
            if (c == sls_pkg::C_QUOTE) begin
               mode_q = P_IDLE;
               add_token(sls_pkg::K_STRING, sls_pkg::E_NONE, tok_start_q,
                         pos_q + 1 - tok_start_q);
            end else if (c == sls_pkg::C_LF) bump_line();
            used = 1'b1;
         end
         P_NUMBER: begin
            if (is_digit(c)) used = 1'b1;
            else begin
               mode_q = P_IDLE;
               if (is_blank(c))
                  add_token(sls_pkg::K_NUMBER, sls_pkg::E_NONE, tok_start_q,
                            pos_q - tok_start_q);
               else begin
                  add_token(sls_pkg::K_NONE, sls_pkg::E_NUMBER, tok_start_q,
                            pos_q - tok_start_q);
                  halted_q = 1'b1;
                  used = 1'b1;
               end
            end
         end
         P_IDENT: begin
            if (is_alpha(c)) begin
               if (word_len_q < KW_CHARS) prefix_q = (prefix_q << 8) | c;
               if (word_len_q < 65535) word_len_q++;
               used = 1'b1;
            end else begin
               mode_q = P_IDLE;
               add_word();
            end
         end
         default: ;
      endcase
   endtask

   task automatic begin_token(input logic [7:0] c);
      string singles;
      singles = "(){},.-+;";
      tok_start_q = pos_q;
      for (int i = 0; i < 9; i++)
         if (c == singles[i]) begin
            add_token(6'(i), sls_pkg::E_NONE, pos_q, 1);
            return;
         end
      case (c) inside
         sls_pkg::C_STAR:    add_token(sls_pkg::K_STAR, sls_pkg::E_NONE, pos_q, 1);
         sls_pkg::C_BANG:    mode_q = P_BANG;
         sls_pkg::C_EQUAL:   mode_q = P_EQUAL;
         sls_pkg::C_LESS:    mode_q = P_LESS;
         sls_pkg::C_GREATER: mode_q = P_GREATER;
         sls_pkg::C_SLASH:   mode_q = P_SLASH;
         sls_pkg::C_SPACE, sls_pkg::C_CR, sls_pkg::C_TAB: ;
         sls_pkg::C_LF:      bump_line();
         sls_pkg::C_QUOTE:   mode_q = P_STRING;
         default: begin
            if (is_digit(c)) mode_q = P_NUMBER;
            else if (is_alpha(c)) begin
               mode_q = P_IDENT;
               prefix_q = {56'd0, c};
               word_len_q = 1;
            end else add_token(sls_pkg::K_NONE, sls_pkg::E_CHAR, pos_q, 1);
         end
      endcase
   endtask

   task automatic predict_tokens(input logic [7:0] c, input bit eos);
      bit used;
      step_out.delete();
      if (halted_q) return;
      if (eos) begin
         case (mode_q) inside
            P_BANG, P_EQUAL, P_LESS, P_GREATER:
               add_token(op_kind(mode_q), sls_pkg::E_NONE, tok_start_q, 1);
            P_SLASH:  add_token(sls_pkg::K_SLASH, sls_pkg::E_NONE, tok_start_q, 1);
            P_STRING: add_token(sls_pkg::K_NONE, sls_pkg::E_STRING, tok_start_q,
                                pos_q - tok_start_q);
            P_NUMBER: add_token(sls_pkg::K_NUMBER, sls_pkg::E_NONE, tok_start_q,
                                pos_q - tok_start_q);
            P_IDENT:  add_word();
            default: ;
         endcase
         mode_q = P_IDLE;
         add_token(sls_pkg::K_END, sls_pkg::E_NONE, pos_q, 0);
      end else begin
         if (pos_q >= SRC_LIMIT) return;
         continue_token(c, used);
         if (!used && !halted_q) begin_token(c);
         pos_q++;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
      token_queue = {token_queue, step_out};
   endtask

   // send one item; predict when accepted; valid stays up for the next item
   task automatic send_byte(input logic [7:0] c, input bit eos);
      int gap;
      if (sender_gaps && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_stall);
      predict_tokens(c, eos);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic reset_model();
      mode_q = P_IDLE; pos_q = 0; tok_start_q = 0; line_q = 1;
      prefix_q = 0; word_len_q = 0; halted_q = 0;
   endtask

   // receiver: random stall bursts, plus an optional long hold-off
   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off--;
         end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(posedge clock);
         end else rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      sls_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_queue.size() == 0) begin
            $display("%0t: unexpected result kind=%0d err=%0d", $time,
                     rsp_token_kind, rsp_error_code);
            fail_count++;
         end else begin
            want = token_queue.pop_front();
            if (rsp_token_kind !== want.token_kind || rsp_error_code !== want.error_code ||
                rsp_start_offset !== want.start_offset ||
                rsp_lexeme_length !== want.lexeme_length ||
                rsp_line_number !== want.line_number ||
                rsp_last_of_run !== want.last_of_run) begin
               $display("%0t: mismatch expected k%0d e%0d s%0d l%0d n%0d t%0d", $time,
                        want.token_kind, want.error_code, want.start_offset,
                        want.lexeme_length, want.line_number, want.last_of_run);
               $display("%0t:          actual   k%0d e%0d s%0d l%0d n%0d t%0d", $time,
                        rsp_token_kind, rsp_error_code, rsp_start_offset,
                        rsp_lexeme_length, rsp_line_number, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_operators();
      send_text("(){},.-+;*! != = == < <= > >= / // note\n");
      send_text("!=<>/");
      send_byte(8'd0, 1'b1);
   endtask

   task automatic test_words_numbers();
      send_text("and class else false func for if nil or print return super this");
      send_text(" true var while returns whilex Foo ab12 \"s\nx\" 42\t7\013");
      send_text("@");
      send_byte(8'h00, 1'b0);
      send_text("\377 99");
      send_byte(8'd0, 1'b1);
      send_text("\"open");
      send_byte(8'd0, 1'b1);
   endtask

   task automatic test_bad_number();
      send_text("12a3;");
      send_byte(8'd0, 1'b1);
   endtask

   // mostly well-formed snippets with some noise
   task automatic test_random_source(input int count);
      string pieces[20] = '{"while", "return", "x", "class", "func", " ", "\n", "(",
         ")", "==", "!=", "<=", ">=", "/", "// c\n", "\"str\"", "123 ", "*", ";", "ident"};
      string s;
      int sent;
      logic [7:0] b;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 15) == 0) begin
            // a stray digit could end the run in the halted state
            b = 8'($urandom);
            if (is_digit(b)) b = sls_pkg::C_SPACE;
            send_byte(b, 1'b0);
            sent++;
         end else if ($urandom_range(0, 60) == 0) begin
            send_byte(8'($urandom), 1'b1);
            sent++;
         end else begin
            s = pieces[$urandom_range(0, 19)];
            send_text(s);
            sent += s.len();
         end
         if (count > 500 && sent > count * 3 / 4) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end
      end
      send_byte(8'd0, 1'b1);
   endtask

   task automatic test_backpressure();
      hold_off = 60;
      send_text("( ) { } ; ; ; , , . . - - + + * *");
      send_byte(8'd0, 1'b1);
   endtask

   initial begin
      int waited;
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operators();
      test_words_numbers();
      test_backpressure();
      test_random_source(2000);
      test_bad_number();
      send_text("abc");
      send_byte(8'd0, 1'b1);
      req_valid <= 1'b0;
      waited = 0;
      while (token_queue.size() > 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && token_queue.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/sls_pkg.sv
hdl/sls_scanner_core.sv
hdl/sls_result_fifo.sv
hdl/script_lexer_scanner_top.sv
bench/tb_script_lexer_scanner_top.sv
